FILE: rtl/ags_pkg.sv
// Shared constants for the advection grid stencil: field widths, register
// indexes and register reset values. No dependencies.
`timescale 1ns / 1ps

package ags_pkg;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 9;
  localparam int GRID_W      = 10;
  localparam int STEP_W      = 17;
  localparam int CFG_IDX_W   = 3;

  localparam int MAX_SIZE_DEF  = 512;
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_R   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_SRC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_T    = 3'd4;

  // Register reset values
  localparam logic [GRID_W-1:0]        GRID_SIZE_RST = 10'd300;
  localparam logic signed [DATA_W-1:0] COEFF_R_RST   = -32'sd21845;
  localparam logic signed [DATA_W-1:0] COEFF_SRC_RST = 32'sd146;
  localparam logic [STEP_W-1:0]        STEP_X_RST    = 17'd218;
  localparam logic [STEP_W-1:0]        STEP_T_RST    = 17'd218;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;

endpackage

FILE: rtl/advection_grid_stencil_top.sv
// Box-scheme advection grid solver: streams cells in row-major order,
// keeps the previous row in an on-chip line buffer. Depends on ags_pkg.
`timescale 1ns / 1ps

//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  input   | in_valid / in_ready       | boundary_value
//  output  | out_valid / out_ready     | cell_value, row, col, last_cell
//  config  | cfg_wr_en (no wait)       | cfg_index, cfg_data
//
// One cell per cycle while the output is not stalled; a cell passes the
// index stage, source product stage, line buffer read and update stage,
// then the output register. The rate is set by the left-neighbor loop:
// one multiply, round and add per cell in the update stage.
// Reset clears counters, pipeline valid bits, configuration and neighbor
// registers; the line buffer holds no reset value and needs no clearing
// pass. A stalled output holds the pipeline stage by stage; the input
// keeps taking cells while any stage is free.

module advection_grid_stencil_top #(
  parameter int MAX_SIZE  = ags_pkg::MAX_SIZE_DEF,
  parameter int FRAC_BITS = ags_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ags_pkg::DATA_W-1:0]    boundary_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ags_pkg::DATA_W-1:0]    cell_value,
  output logic [ags_pkg::IDX_W-1:0]            row,
  output logic [ags_pkg::IDX_W-1:0]            col,
  output logic                                 last_cell,
  input  logic                                 cfg_wr_en,
  input  logic [ags_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ags_pkg::DATA_W-1:0]           cfg_data
);

  localparam int DW      = ags_pkg::DATA_W;
  localparam int CW      = $clog2(MAX_SIZE);
  localparam int SW      = ags_pkg::STEP_W;
  localparam int TERM_W  = CW + 1 + SW;
  localparam int ST_W    = TERM_W + 1;
  localparam int MR_W    = 2 * DW + 1;
  localparam int P_W     = MR_W + 1 - FRAC_BITS;
  localparam int MS_W    = DW + ST_W + 1;
  localparam int S_W     = MS_W + 1 - FRAC_BITS - 1;
  localparam int ACC_W   = MR_W + 2;

  localparam logic signed [MR_W:0] R_HALF = (MR_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [MS_W:0] S_HALF = (MS_W+1)'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(ags_pkg::DATA_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(ags_pkg::DATA_MIN);

  // Configuration registers
  logic [ags_pkg::GRID_W-1:0] grid_size;
  logic signed [DW-1:0]       coeff_r;
  logic signed [DW-1:0]       coeff_src;
  logic [SW-1:0]              step_x;
  logic [SW-1:0]              step_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= ags_pkg::GRID_SIZE_RST;
      coeff_r   <= ags_pkg::COEFF_R_RST;
      coeff_src <= ags_pkg::COEFF_SRC_RST;
      step_x    <= ags_pkg::STEP_X_RST;
      step_t    <= ags_pkg::STEP_T_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ags_pkg::REG_GRID_SIZE: grid_size <= cfg_data[ags_pkg::GRID_W-1:0];
        ags_pkg::REG_COEFF_R:   coeff_r   <= $signed(cfg_data);
        ags_pkg::REG_COEFF_SRC: coeff_src <= $signed(cfg_data);
        ags_pkg::REG_STEP_X:    step_x    <= cfg_data[SW-1:0];
        ags_pkg::REG_STEP_T:    step_t    <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Last valid index, with the grid size clamped to [2, MAX_SIZE]
  logic [CW-1:0] last_idx;

  always_comb begin
    priority if (grid_size < ags_pkg::GRID_W'(2)) begin
      last_idx = CW'(1);
    end else if (32'(grid_size) > MAX_SIZE) begin
      last_idx = CW'(MAX_SIZE - 1);
    end else begin
      last_idx = CW'(32'(grid_size) - 32'd1);
    end
  end

  // Pipeline handshakes
  logic s1_valid, s2_valid, s3_valid;
  logic in_xfer, s2_load, s3_load, out_load;

  assign out_load = s3_valid && (!out_valid || out_ready);
  assign s3_load  = s2_valid && (!s3_valid || out_load);
  assign s2_load  = s1_valid && (!s2_valid || s3_load);
  assign in_ready = !s1_valid || s2_load;
  assign in_xfer  = in_valid && in_ready;

  // Cell counters
  logic [CW-1:0] row_counter, col_counter;
  logic [CW-1:0] row_counter_next, col_counter_next;
  logic          row_end, col_end;

  assign col_end = col_counter >= last_idx;
  assign row_end = row_counter >= last_idx;

  always_comb begin
    row_counter_next = row_counter;
    col_counter_next = col_counter + CW'(1);
    if (col_end) begin
      col_counter_next = '0;
      row_counter_next = row_end ? '0 : row_counter + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
    end else if (in_xfer) begin
      row_counter <= row_counter_next;
      col_counter <= col_counter_next;
    end
  end

  // Twice the source offsets: (2i-1)*h + (2j-1)*d
  logic [CW:0]     odd_i, odd_j;
  logic [TERM_W-1:0] term_x, term_t;

  assign odd_i  = {row_counter - CW'(1), 1'b1};
  assign odd_j  = {col_counter - CW'(1), 1'b1};
  assign term_x = TERM_W'(odd_i) * TERM_W'(step_x);
  assign term_t = TERM_W'(odd_j) * TERM_W'(step_t);

  // Stage 1: indexes and source sum
  logic [CW-1:0]        s1_i, s1_j;
  logic                 s1_bnd, s1_last;
  logic signed [DW-1:0] s1_bval;
  logic [ST_W-1:0]      s1_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_i    <= row_counter;
      s1_j    <= col_counter;
      s1_bnd  <= (row_counter == '0) || (col_counter == '0);
      s1_last <= col_end && row_end;
      s1_bval <= boundary_value;
      s1_sum  <= ST_W'(term_x) + ST_W'(term_t);
    end
  end

  // Stage 2: rounded source term
  logic signed [MS_W-1:0] prod_s;
  logic signed [MS_W:0]   s_sum;

  assign prod_s = MS_W'(coeff_src) * MS_W'($signed({1'b0, s1_sum}));
  assign s_sum  = (MS_W+1)'(prod_s) + S_HALF;

  logic [CW-1:0]        s2_i, s2_j;
  logic                 s2_bnd, s2_last;
  logic signed [DW-1:0] s2_bval;
  logic signed [S_W-1:0] s2_src;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (s3_load) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_i    <= s1_i;
      s2_j    <= s1_j;
      s2_bnd  <= s1_bnd;
      s2_last <= s1_last;
      s2_bval <= s1_bval;
      s2_src  <= $signed(s_sum[MS_W:FRAC_BITS+1]);
    end
  end

  // Stage 3: line buffer read, then the cell update
  logic signed [DW-1:0] row_store [MAX_SIZE];
  logic signed [DW-1:0] s3_above;
  logic [CW-1:0]        s3_i, s3_j;
  logic                 s3_bnd, s3_last;
  logic signed [DW-1:0] s3_bval;
  logic signed [S_W-1:0] s3_src;
  logic signed [DW-1:0] cell_result;

  // The entry read here is never the one written at the same edge: the
  // writer is the preceding cell, which always sits in another column.
  always_ff @(posedge clk) begin
    if (out_load) begin
      row_store[s3_j] <= cell_result;
    end
    if (s3_load) begin
      s3_above <= row_store[s2_j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_load) begin
      s3_valid <= 1'b1;
    end else if (out_load) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_i    <= s2_i;
      s3_j    <= s2_j;
      s3_bnd  <= s2_bnd;
      s3_last <= s2_last;
      s3_bval <= s2_bval;
      s3_src  <= s2_src;
    end
  end

  logic signed [DW-1:0] left_value, upper_left_value;
  logic signed [DW:0]   diff;
  logic signed [MR_W-1:0] prod_r;
  logic signed [MR_W:0]   p_sum;
  logic signed [P_W-1:0]  p_val;
  logic signed [ACC_W-1:0] acc;

  assign diff   = (DW+1)'(left_value) - (DW+1)'(s3_above);
  assign prod_r = MR_W'(coeff_r) * MR_W'(diff);
  assign p_sum  = (MR_W+1)'(prod_r) + R_HALF;
  assign p_val  = $signed(p_sum[MR_W:FRAC_BITS]);
  assign acc    = ACC_W'(upper_left_value) + ACC_W'(p_val) + ACC_W'(s3_src);

  always_comb begin
    priority if (s3_bnd) begin
      cell_result = s3_bval;
    end else if (acc > ACC_MAX) begin
      cell_result = ags_pkg::DATA_MAX;
    end else if (acc < ACC_MIN) begin
      cell_result = ags_pkg::DATA_MIN;
    end else begin
      cell_result = DW'(acc);
    end
  end

  // Advance the neighbor registers as the cell leaves the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_value       <= '0;
      upper_left_value <= '0;
    end else if (out_load) begin
      left_value       <= cell_result;
      upper_left_value <= s3_above;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_value <= cell_result;
      row        <= ags_pkg::IDX_W'(s3_i);
      col        <= ags_pkg::IDX_W'(s3_j);
      last_cell  <= s3_last;
    end
  end

endmodule
